FILE: rtl/ffpa_pkg.sv
// ----------------------------------------------------------------------------
// ffpa_pkg
// shared types and constants of the first-free page allocator
// ----------------------------------------------------------------------------
package ffpa_pkg;

  localparam int ADDR_W        = 32;
  localparam int PAGE_SHIFT    = 12;
  localparam int FP_W          = ADDR_W - PAGE_SHIFT;   // page number width
  localparam int WORD_BITS     = 32;                    // used bits per cell
  localparam int WORD_SHIFT    = 5;
  localparam int PAGE_IDX_W    = 16;                    // covers the largest page count
  localparam int WORD_IDX_W    = PAGE_IDX_W - WORD_SHIFT;
  localparam int MANAGED_PAGES_DEF = 1024;
  localparam logic [FP_W-1:0] FIRST_PAGE_RST = FP_W'(256);

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_OOM   = 3'd1,
    ST_BELOW = 3'd2,
    ST_FREE  = 3'd3,
    ST_ABOVE = 3'd4
  } status_t;

  typedef enum logic {
    ACT_ALLOC   = 1'b0,
    ACT_RELEASE = 1'b1
  } action_t;

  typedef struct packed {
    logic              action;
    logic [ADDR_W-1:0] release_address;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] page_address;
    status_t           status;
  } rsp_t;

  // token handed from cell to cell
  typedef struct packed {
    logic                  valid;
    action_t               action;
    logic                  done;    // request already settled upstream
    logic [PAGE_IDX_W-1:0] page;    // page index inside the managed area
    status_t               status;
  } tok_t;

endpackage

FILE: rtl/ffpa_cell.sv
// ----------------------------------------------------------------------------
// ffpa_cell
// one cell of the allocator chain: holds a word of used bits and settles
// the passing token if the request belongs to it
// ----------------------------------------------------------------------------
module ffpa_cell #(
  parameter int CELL_ID    = 0,
  parameter int VALID_BITS = ffpa_pkg::WORD_BITS
) (
  input  logic            clk,
  input  logic            rst,
  input  ffpa_pkg::tok_t  tok_in,
  output ffpa_pkg::tok_t  tok_out
);

  localparam logic [ffpa_pkg::WORD_IDX_W-1:0] ID = ffpa_pkg::WORD_IDX_W'(CELL_ID);

  logic [ffpa_pkg::WORD_BITS-1:0]  used;
  logic [ffpa_pkg::WORD_BITS-1:0]  used_next;
  logic [ffpa_pkg::WORD_BITS-1:0]  mask;
  logic [ffpa_pkg::WORD_BITS-1:0]  avail;
  logic [ffpa_pkg::WORD_SHIFT-1:0] pos;
  logic [ffpa_pkg::WORD_SHIFT-1:0] bit_sel;
  logic                            hit_word;
  ffpa_pkg::tok_t                  tok_next;

  // bits past the managed page count never look free
  always_comb begin
    for (int j = 0; j < ffpa_pkg::WORD_BITS; j++) begin
      mask[j] = (j < VALID_BITS);
    end
  end

  assign avail = ~used & mask;

  // lowest free bit
  always_comb begin
    pos = '0;
    for (int j = ffpa_pkg::WORD_BITS - 1; j >= 0; j--) begin
      if (avail[j]) begin
        pos = ffpa_pkg::WORD_SHIFT'(j);
      end
    end
  end

  assign hit_word = (tok_in.page[ffpa_pkg::PAGE_IDX_W-1:ffpa_pkg::WORD_SHIFT] == ID);
  assign bit_sel  = tok_in.page[ffpa_pkg::WORD_SHIFT-1:0];

  always_comb begin
    tok_next  = tok_in;
    used_next = used;
    if (tok_in.valid && !tok_in.done) begin
      if (tok_in.action == ffpa_pkg::ACT_ALLOC) begin
        if (|avail) begin
          used_next[pos]  = 1'b1;
          tok_next.done   = 1'b1;
          tok_next.page   = {ID, pos};
          tok_next.status = ffpa_pkg::ST_OK;
        end
      end else if (hit_word) begin
        tok_next.done = 1'b1;
        if (used[bit_sel]) begin
          used_next[bit_sel] = 1'b0;
          tok_next.status    = ffpa_pkg::ST_OK;
        end else begin
          tok_next.status    = ffpa_pkg::ST_FREE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
      used    <= '0;
    end else begin
      tok_out <= tok_next;
      used    <= used_next;
    end
  end

endmodule

FILE: rtl/first_free_page_allocator.sv
// ----------------------------------------------------------------------------
// first_free_page_allocator
// path: the token passes the NUM_CELLS cell registers, then the output register,
//   the same for allocate and free (32 cells for 1024 pages)
// intake: a new word is taken only once the last token has left the cell
//   chain, which it walks one cell per cycle, and the skid entry is empty
// reset: synchronous; clears every used bit at once and sets first_page to 256
// ----------------------------------------------------------------------------
module first_free_page_allocator #(
  parameter int MANAGED_PAGES = ffpa_pkg::MANAGED_PAGES_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  // configuration: first managed page number
  input  logic                      cfg_we,
  input  logic [ffpa_pkg::FP_W-1:0] cfg_data,
  // request words
  input  logic                      in_valid,
  output logic                      in_ready,
  input  ffpa_pkg::req_t            in_data,
  // result words
  output logic                      out_valid,
  input  logic                      out_ready,
  output ffpa_pkg::rsp_t            out_data
);

  localparam int NUM_CELLS =
    (MANAGED_PAGES + ffpa_pkg::WORD_BITS - 1) / ffpa_pkg::WORD_BITS;

  // configuration register; the user must write it only while idle, the block does not enforce it
  logic [ffpa_pkg::FP_W-1:0] first_page;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_page <= ffpa_pkg::FIRST_PAGE_RST;
    end else if (cfg_we) begin
      first_page <= cfg_data;
    end
  end

  // --------------------------------------------------------------------------
  // entry: range check of a free request before it joins the chain
  // --------------------------------------------------------------------------
  logic                      accept;
  logic [ffpa_pkg::FP_W-1:0] rel_page;
  logic [ffpa_pkg::FP_W-1:0] rel_off;
  logic                      below;
  logic                      above;
  logic                      releasing;

  assign accept    = in_valid && in_ready;
  assign releasing = (in_data.action == ffpa_pkg::ACT_RELEASE);
  assign rel_page  = in_data.release_address[ffpa_pkg::ADDR_W-1:ffpa_pkg::PAGE_SHIFT];
  assign below     = rel_page < first_page;
  assign rel_off   = rel_page - first_page;
  assign above     = !below && (rel_off >= ffpa_pkg::FP_W'(MANAGED_PAGES));

  ffpa_pkg::tok_t head;
  ffpa_pkg::tok_t chain [NUM_CELLS+1];

  always_comb begin
    head.valid  = accept;
    head.action = ffpa_pkg::action_t'(in_data.action);
    // out-of-range frees ride along already settled, so cells leave them alone
    head.done   = releasing && (below || above);
    head.page   = rel_off[ffpa_pkg::PAGE_IDX_W-1:0];
    if (below) begin
      head.status = ffpa_pkg::ST_BELOW;
    end else if (above) begin
      head.status = ffpa_pkg::ST_ABOVE;
    end else begin
      head.status = ffpa_pkg::ST_OK;
    end
  end

  assign chain[0] = head;

  // --------------------------------------------------------------------------
  // cell chain: each cell owns 32 used bits; an allocate token is claimed by
  // the first cell with a free bit, a free token by the cell owning the page
  // --------------------------------------------------------------------------
  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    localparam int REMAIN = MANAGED_PAGES - k * ffpa_pkg::WORD_BITS;
    localparam int VB     = (REMAIN >= ffpa_pkg::WORD_BITS) ? ffpa_pkg::WORD_BITS : REMAIN;

    ffpa_cell #(
      .CELL_ID    (k),
      .VALID_BITS (VB)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (chain[k]),
      .tok_out (chain[k+1])
    );
  end

  // --------------------------------------------------------------------------
  // exit: turn the token into a result word
  // --------------------------------------------------------------------------
  ffpa_pkg::tok_t            tail;
  ffpa_pkg::rsp_t            res;
  logic [ffpa_pkg::FP_W-1:0] alloc_page;
  logic                      granted;

  assign tail       = chain[NUM_CELLS];
  assign granted    = (tail.action == ffpa_pkg::ACT_ALLOC) && tail.done;
  // page number wraps at 20 bits, address keeps the low 32 bits
  assign alloc_page = first_page + ffpa_pkg::FP_W'(tail.page);

  always_comb begin
    res.page_address = granted ? {alloc_page, {ffpa_pkg::PAGE_SHIFT{1'b0}}} : '0;
    if (tail.action == ffpa_pkg::ACT_ALLOC && !tail.done) begin
      res.status = ffpa_pkg::ST_OOM;   // no cell had a free page
    end else begin
      res.status = tail.status;
    end
  end

  // --------------------------------------------------------------------------
  // output register plus one skid entry, so the chain never has to stall
  // --------------------------------------------------------------------------
  logic           in_flight;
  logic           pend_valid;
  ffpa_pkg::rsp_t pend;
  logic           out_take;

  assign out_take = out_valid && out_ready;
  assign in_ready = !in_flight && !pend_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_flight  <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (accept) begin
        in_flight <= 1'b1;
      end else if (tail.valid) begin
        in_flight <= 1'b0;
      end

      if (pend_valid && (!out_valid || out_take)) begin
        out_data   <= pend;
        out_valid  <= 1'b1;
        pend_valid <= 1'b0;
      end else if (tail.valid) begin
        if (!out_valid || out_take) begin
          out_data  <= res;
          out_valid <= 1'b1;
        end else begin
          pend       <= res;
          pend_valid <= 1'b1;
        end
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // checks
  // --------------------------------------------------------------------------
  logic [NUM_CELLS:0] chain_valid;

  always_comb begin
    for (int k = 0; k <= NUM_CELLS; k++) begin
      chain_valid[k] = chain[k].valid;
    end
  end

  // only one request is ever in the chain
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $countones(chain_valid) <= 1)
    else $error("more than one token in the cell chain");

  // a token leaves the chain only while a request is outstanding
  a_tail_in_flight: assert property (@(posedge clk) disable iff (rst)
    tail.valid |-> in_flight)
    else $error("token at chain end without a request in flight");

  // an accepted request is tracked as in flight
  a_accept_flight: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_flight)
    else $error("accepted request not marked in flight");

  // the skid entry is used only behind a full output register
  a_pend_behind_out: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> out_valid)
    else $error("skid entry holds a word while the output register is empty");

endmodule

FILE: sim/first_free_page_allocator_tb.sv
// ----------------------------------------------------------------------------
// first_free_page_allocator_tb
// self-checking bench for the first-free page allocator: a cycle-free model of
// the used-bit map predicts each result word, directed words hit the edges of
// the managed area, then long random runs fill the map to out-of-memory and
// release pages again under random idling and a long output stall
// ----------------------------------------------------------------------------
module first_free_page_allocator_tb;
  import ffpa_pkg::*;

  localparam int MANAGED_PAGES  = MANAGED_PAGES_DEF;
  localparam int FIRST_PAGE_MAX = (1 << FP_W) - MANAGED_PAGES;   // highest legal base
  localparam int DRAIN_CYCLES   = 40;     // margin beyond the block latency
  localparam int LONG_STALL     = 300;    // output hold-off in the pressure test

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  // block inputs start at known values
  logic            cfg_we   = 1'b0;
  logic [FP_W-1:0] cfg_data = FIRST_PAGE_RST;
  logic            in_valid = 1'b0;
  req_t            in_data  = '0;
  logic            out_ready = 1'b0;

  // block outputs
  logic in_ready;
  logic out_valid;
  rsp_t out_data;

  // model state: one used bit per managed page and the current base page
  bit [MANAGED_PAGES-1:0] page_busy;
  logic [FP_W-1:0]        base_page;

  // result words still owed by the block, oldest first
  rsp_t pending_rsp_q[$];

  // bookkeeping
  int mismatch_count  = 0;
  int words_sent      = 0;
  int results_checked = 0;
  int base_writes     = 0;
  int alloc_granted   = 0;
  int status_tally[5];

  // knobs shared with the ready driver
  bit no_idle       = 1'b0;
  int stall_request = 0;

  always #4 clk = ~clk;

  first_free_page_allocator #(
    .MANAGED_PAGES(MANAGED_PAGES)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // --------------------------------------------------------------------------
  // page map model
  // --------------------------------------------------------------------------

  // applies one request word to the model map and returns the result word
  function automatic rsp_t predict_page_op(input req_t req);
    rsp_t            r;
    int              slot;
    logic [FP_W-1:0] pn;
    logic [FP_W-1:0] rel_idx;
    r.page_address = '0;
    r.status       = ST_OK;
    if (req.action == ACT_ALLOC) begin
      // scan downward so the lowest clear bit wins
      slot = -1;
      for (int i = MANAGED_PAGES - 1; i >= 0; i--) begin
        if (!page_busy[i]) slot = i;
      end
      if (slot < 0) begin
        r.status = ST_OOM;
      end else begin
        page_busy[slot] = 1'b1;
        // page number kept to its 20 bits, so the byte address wraps like 32-bit math
        r.page_address = {base_page + FP_W'(slot), {PAGE_SHIFT{1'b0}}};
        alloc_granted++;
      end
    end else begin
      pn = req.release_address[ADDR_W-1:PAGE_SHIFT];
      if (pn < base_page) begin
        r.status = ST_BELOW;
      end else begin
        rel_idx = pn - base_page;
        if (rel_idx >= MANAGED_PAGES) begin
          r.status = ST_ABOVE;
        end else if (!page_busy[rel_idx]) begin
          r.status = ST_FREE;
        end else begin
          page_busy[rel_idx] = 1'b0;
        end
      end
    end
    status_tally[r.status]++;
    return r;
  endfunction

  // random byte address inside the given page
  function automatic logic [ADDR_W-1:0] addr_in_page(input logic [FP_W-1:0] pn);
    logic [PAGE_SHIFT-1:0] off;
    off = PAGE_SHIFT'($urandom_range(0, (1 << PAGE_SHIFT) - 1));
    return {pn, off};
  endfunction

  // random managed page whose used bit equals want_busy, -1 if there is none
  function automatic int pick_page(input bit want_busy);
    int start;
    int pick;
    int k;
    start = $urandom_range(0, MANAGED_PAGES - 1);
    pick  = -1;
    for (k = 0; k < MANAGED_PAGES; k++) begin
      if (pick < 0 && page_busy[(start + k) % MANAGED_PAGES] == want_busy)
        pick = (start + k) % MANAGED_PAGES;
    end
    return pick;
  endfunction

  // --------------------------------------------------------------------------
  // shared driver, checker and helpers
  // --------------------------------------------------------------------------

  task automatic flag_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  // offers one request word and predicts its result once it is taken
  task automatic send_word(input action_t act, input logic [ADDR_W-1:0] addr);
    req_t word;
    rsp_t outcome;
    int   gap;
    word.action          = act;
    word.release_address = addr;
    // optional sender gap; valid only drops here, never in the step it rises
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= word;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    outcome = predict_page_op(word);
    pending_rsp_q.push_back(outcome);
    words_sent++;
  endtask

  // drops valid and waits until every owed result word is back
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_rsp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // base page write, only with the block idle
  task automatic write_first_page(input logic [FP_W-1:0] value);
    settle();
    cfg_data <= value;
    cfg_we   <= 1'b1;
    @(posedge clk);
    cfg_we   <= 1'b0;
    base_page = value;
    base_writes++;
  endtask

  // one random word: good_pct percent well-formed alloc/release, the rest malformed releases
  task automatic send_mixed_word(input int good_pct);
    int              busy_idx;
    int              idle_idx;
    logic [FP_W-1:0] pn;
    busy_idx = pick_page(1'b1);
    if ($urandom_range(0, 99) < good_pct) begin
      if (busy_idx >= 0 && $urandom_range(0, 99) < 45) begin
        pn = base_page + FP_W'(busy_idx);
        send_word(ACT_RELEASE, addr_in_page(pn));
      end else begin
        // address is don't-care on allocate, so it carries random junk
        send_word(ACT_ALLOC, ADDR_W'($urandom));
      end
    end else begin
      case ($urandom_range(0, 3))
        0: send_word(ACT_RELEASE, ADDR_W'($urandom));
        1: begin
          if (base_page != 0) begin
            pn = FP_W'($urandom_range(0, int'(base_page) - 1));
            send_word(ACT_RELEASE, addr_in_page(pn));
          end else begin
            send_word(ACT_RELEASE, ADDR_W'($urandom));
          end
        end
        2: begin
          if (int'(base_page) + MANAGED_PAGES <= (1 << FP_W) - 1) begin
            pn = FP_W'($urandom_range(int'(base_page) + MANAGED_PAGES, (1 << FP_W) - 1));
            send_word(ACT_RELEASE, addr_in_page(pn));
          end else begin
            send_word(ACT_RELEASE, ADDR_W'($urandom));
          end
        end
        default: begin
          // release of a page that is not held
          idle_idx = pick_page(1'b0);
          if (idle_idx >= 0) begin
            pn = base_page + FP_W'(idle_idx);
            send_word(ACT_RELEASE, addr_in_page(pn));
          end else begin
            send_word(ACT_RELEASE, ADDR_W'($urandom));
          end
        end
      endcase
    end
  endtask

  // out_ready driver: random low bursts, or a long hold when a test asks
  initial begin : ready_drive
    int low_left;
    low_left = 0;
    forever begin
      @(posedge clk);
      if (stall_request > 0) begin
        low_left      = stall_request;
        stall_request = 0;
      end else if (low_left == 0 && !no_idle && $urandom_range(0, 5) == 0) begin
        low_left = $urandom_range(1, 4);
      end
      if (low_left > 0) begin
        out_ready <= 1'b0;
        low_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // compares every taken result word with the oldest prediction
  initial begin : result_check
    rsp_t got;
    rsp_t want;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        got = out_data;
        if (pending_rsp_q.size() == 0) begin
          flag_mismatch($sformatf("result word with nothing owed: addr %h status %0d",
                                  got.page_address, got.status));
        end else begin
          want = pending_rsp_q.pop_front();
          results_checked++;
          if (got.page_address !== want.page_address)
            flag_mismatch($sformatf("page_address %h, expected %h",
                                    got.page_address, want.page_address));
          if (got.status !== want.status)
            flag_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // reset base 256: first grants, double release, both sides of the managed area
  task automatic test_reset_directed();
    send_word(ACT_ALLOC, 32'h0000_0000);
    send_word(ACT_ALLOC, 32'h0000_0000);
    send_word(ACT_ALLOC, 32'hFFFF_FFFF);   // address ignored on allocate
    send_word(ACT_RELEASE, 32'h0010_1FFF); // last byte of the second page
    send_word(ACT_RELEASE, 32'h0010_1000); // same page again, already free
    send_word(ACT_ALLOC, 32'h0000_0000);   // the hole is reused first
    send_word(ACT_RELEASE, 32'h0000_0000); // bottom of memory, below
    send_word(ACT_RELEASE, 32'h000F_FFFF); // page just under the base
    send_word(ACT_RELEASE, 32'h0050_0000); // first page past the area
    send_word(ACT_RELEASE, 32'hFFFF_FFFF); // top of memory, above
    send_word(ACT_RELEASE, 32'h004F_F123); // last managed page, never held
    send_word(ACT_RELEASE, 32'h0010_0000); // first managed page
  endtask

  // base at 0 and at its maximum, with grants and releases at both ends
  task automatic test_first_page_extremes();
    write_first_page('0);
    send_word(ACT_ALLOC, 32'h0000_0000);   // page 0 granted, byte address 0
    send_word(ACT_RELEASE, 32'h0000_0ABC);
    send_word(ACT_RELEASE, 32'h003F_F000); // last managed page, not held
    send_word(ACT_RELEASE, 32'h0040_0000); // first page past the area
    write_first_page(FP_W'(FIRST_PAGE_MAX));
    send_word(ACT_ALLOC, 32'h1234_5678);
    send_word(ACT_RELEASE, 32'hFFFF_FFFF); // last page of the address space
    send_word(ACT_RELEASE, 32'hFFBF_FFFF); // one byte below the area
    send_word(ACT_RELEASE, 32'hFFC0_0000);
  endtask

  // random alloc/release traffic around a random base
  task automatic test_random_mix();
    write_first_page(FP_W'($urandom_range(0, FIRST_PAGE_MAX)));
    repeat (380) send_mixed_word(75);
  endtask

  // output held off long enough that the block backs up into its input
  task automatic test_output_backpressure();
    stall_request = LONG_STALL;
    repeat (12) send_mixed_word(100);
  endtask

  // allocate until the map is full, then out of memory, then one hole reused
  task automatic test_fill_to_out_of_memory();
    int              idx;
    logic [FP_W-1:0] pn;
    write_first_page(FP_W'($urandom_range(0, FIRST_PAGE_MAX)));
    while ($countones(page_busy) < MANAGED_PAGES) begin
      if ($urandom_range(0, 9) == 0) send_mixed_word(50);
      else send_word(ACT_ALLOC, ADDR_W'($urandom));
    end
    repeat (4) send_word(ACT_ALLOC, ADDR_W'($urandom));
    idx = pick_page(1'b1);
    pn  = base_page + FP_W'(idx);
    send_word(ACT_RELEASE, addr_in_page(pn));
    send_word(ACT_ALLOC, ADDR_W'($urandom));
    send_word(ACT_ALLOC, ADDR_W'($urandom));
  endtask

  // back-to-back traffic with no idling on either side
  task automatic test_tail_no_idle();
    write_first_page(FIRST_PAGE_RST);
    no_idle = 1'b1;
    repeat (80) send_mixed_word(90);
  endtask

  // --------------------------------------------------------------------------
  // run sequence
  // --------------------------------------------------------------------------
  initial begin : run_tests
    for (int s = 0; s < 5; s++) status_tally[s] = 0;
    page_busy = '0;
    base_page = FIRST_PAGE_RST;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_directed();
    test_first_page_extremes();
    test_random_mix();
    test_output_backpressure();
    test_fill_to_out_of_memory();
    test_tail_no_idle();
    settle();

    $display("covered %0d request words, %0d result words checked, %0d base page writes",
             words_sent, results_checked, base_writes);
    $display("grants %0d, out of memory %0d, releases ok %0d, below %0d, not held %0d, above %0d",
             alloc_granted, status_tally[ST_OOM], status_tally[ST_OK] - alloc_granted,
             status_tally[ST_BELOW], status_tally[ST_FREE], status_tally[ST_ABOVE]);
    if (mismatch_count == 0) begin
      $display("** first_free_page_allocator: PASSED **");
    end else begin
      $display("** first_free_page_allocator: FAILED **");
    end
    $finish;
  end

  // hard stop well beyond the slowest correct run
  initial begin : run_limit
    #4000000;
    $display("timeout with %0d result words still owed", pending_rsp_q.size());
    $display("** first_free_page_allocator: FAILED **");
    $finish;
  end

endmodule
